// ===== rtl/scfl_pkg.sv =====
// ----------------------------------------------------------------------------
// scfl_pkg: shared types and constants of the size-class free-list allocator
// Payload structs, status codes, controller states and the command/status
// bundles that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package scfl_pkg;

   // sizing defaults
   localparam int unsigned DEF_REGION_PAGES = 64;
   localparam int unsigned DEF_CLASS_COUNT  = 9;
   localparam int unsigned GRANULE_BYTES    = 16;
   localparam int unsigned PAGE_BYTES       = 4096;
   localparam int unsigned PAGE_GRANULES    = 256;
   localparam logic [6:0]  LIMIT_RESET      = 7'd64;

   // request kinds
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [23:0] request_size;
      logic [17:0] user_address;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [17:0] granted_address;
      logic [3:0]  size_class;
      logic [12:0] large_pages;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      STATUS_ALLOCATED    = 3'd0,
      STATUS_FREED        = 3'd1,
      STATUS_ZERO_SIZE    = 3'd2,
      STATUS_OUT_OF_PAGES = 3'd3,
      STATUS_LARGE        = 3'd4,
      STATUS_BAD_POINTER  = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_REFILL,
      S_REFILL_END,
      S_POP_READ,
      S_POP,
      S_FREE_CHECK,
      S_DELIVER
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       capture;
      logic       refill_start;
      logic       refill_step;
      logic       refill_end;
      logic       pop_commit;
      logic       free_commit;
      logic       load_result;
      status_type result_status;
      logic       deliver;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic kind_free;
      logic zero_size;
      logic oversize;
      logic head_empty;
      logic no_page;
      logic addr_bad;
      logic tag_bad;
      logic refill_last;
   } dp_status_type;

endpackage

// ===== rtl/scfl_ctrl.sv =====
// ----------------------------------------------------------------------------
// scfl_ctrl: allocator sequencer
// Walks one request through decode, page refill, pop or free, and hands
// the result beat to the output register.
// ----------------------------------------------------------------------------
module scfl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  scfl_pkg::dp_status_type dp_status,
   output scfl_pkg::dp_cmd_type    dp_cmd
);
   import scfl_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // state and output valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      dp_cmd    = '0;
      dp_cmd.result_status = STATUS_ALLOCATED;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               dp_cmd.capture = 1'b1;
               state_in       = S_DECODE;
            end
         end
         S_DECODE: begin
            if (dp_status.kind_free) begin
               if (dp_status.addr_bad) begin
                  dp_cmd.load_result   = 1'b1;
                  dp_cmd.result_status = STATUS_BAD_POINTER;
                  state_in             = S_DELIVER;
               end else begin
                  state_in = S_FREE_CHECK;
               end
            end else begin
               priority if (dp_status.zero_size) begin
                  dp_cmd.load_result   = 1'b1;
                  dp_cmd.result_status = STATUS_ZERO_SIZE;
                  state_in             = S_DELIVER;
               end else if (dp_status.oversize) begin
                  dp_cmd.load_result   = 1'b1;
                  dp_cmd.result_status = STATUS_LARGE;
                  state_in             = S_DELIVER;
               end else if (dp_status.head_empty && dp_status.no_page) begin
                  dp_cmd.load_result   = 1'b1;
                  dp_cmd.result_status = STATUS_OUT_OF_PAGES;
                  state_in             = S_DELIVER;
               end else if (dp_status.head_empty) begin
                  dp_cmd.refill_start = 1'b1;
                  state_in            = S_REFILL;
               end else begin
                  state_in = S_POP;
               end
            end
         end
         S_REFILL: begin
            dp_cmd.refill_step = 1'b1;
            if (dp_status.refill_last) begin
               state_in = S_REFILL_END;
            end
         end
         S_REFILL_END: begin
            dp_cmd.refill_end = 1'b1;
            state_in          = S_POP_READ;
         end
         S_POP_READ: begin
            state_in = S_POP;
         end
         S_POP: begin
            dp_cmd.pop_commit    = 1'b1;
            dp_cmd.load_result   = 1'b1;
            dp_cmd.result_status = STATUS_ALLOCATED;
            state_in             = S_DELIVER;
         end
         S_FREE_CHECK: begin
            dp_cmd.load_result = 1'b1;
            if (dp_status.tag_bad) begin
               dp_cmd.result_status = STATUS_BAD_POINTER;
            end else begin
               dp_cmd.free_commit   = 1'b1;
               dp_cmd.result_status = STATUS_FREED;
            end
            state_in = S_DELIVER;
         end
         S_DELIVER: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               dp_cmd.deliver = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register holds the beat until taken
   assign rsp_valid_in = dp_cmd.deliver | (rsp_valid_ff & rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_to_decode: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_DECODE)
      else $error("accepted request did not enter decode");

   a_rsp_from_deliver: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DELIVER))
      else $error("result beat raised outside deliver");

   a_refill_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_REFILL && dp_status.refill_last |=> state_ff == S_REFILL_END)
      else $error("refill walk did not close");
`endif

endmodule

// ===== rtl/scfl_datapath.sv =====
// ----------------------------------------------------------------------------
// scfl_datapath: class lists, link and tag memories, result registers
// Decodes the captured request, walks a fresh page during refill and
// performs the pop and free read-modify-writes on command.
// ----------------------------------------------------------------------------
module scfl_datapath #(
   parameter int unsigned REGION_PAGES = scfl_pkg::DEF_REGION_PAGES,
   parameter int unsigned CLASS_COUNT  = scfl_pkg::DEF_CLASS_COUNT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  scfl_pkg::req_payload_type req_payload,
   input  logic                     csr_write_enable,
   input  logic [6:0]               csr_write_data,
   input  scfl_pkg::dp_cmd_type      dp_cmd,
   output scfl_pkg::dp_status_type   dp_status,
   output scfl_pkg::rsp_payload_type rsp_payload
);
   import scfl_pkg::*;

   localparam int unsigned GRANULES = REGION_PAGES * PAGE_GRANULES;
   localparam int unsigned GIDX_W   = $clog2(GRANULES);
   localparam int unsigned LINK_W   = $clog2(GRANULES + 1);
   localparam int unsigned PAGE_W   = $clog2(REGION_PAGES + 1);
   localparam int unsigned CLS_W    = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
   localparam int unsigned LARGEST  = GRANULE_BYTES << (CLASS_COUNT - 1);

   req_payload_type req_ff;
   rsp_payload_type res_ff, res_in, rsp_ff;
   logic [6:0]        limit_ff;
   logic [PAGE_W-1:0] nfp_ff;
   logic [LINK_W-1:0] heads_ff [CLASS_COUNT];
   logic [7:0]        fill_ff;
   logic [LINK_W-1:0] prev_ff;

   logic [LINK_W-1:0] link_mem [GRANULES];
   logic [3:0]        tag_mem  [GRANULES];
   logic [LINK_W-1:0] link_rd_ff;
   logic [3:0]        tag_rd_ff;

   logic [24:0]       total;
   logic [25:0]       page_sum;
   logic [CLS_W-1:0]  alloc_cls;
   logic [31:0]       free_g_full;
   logic [GIDX_W-1:0] free_g;
   logic [3:0]        tag_val;
   logic [3:0]        free_cls;
   logic [CLS_W-1:0]  head_idx;
   logic [LINK_W-1:0] head_val;
   logic [LINK_W-1:0] head_m1;
   logic [GIDX_W-1:0] pop_g;
   logic [31:0]       limit_eff;
   logic [31:0]       refill_g_full;
   logic [GIDX_W-1:0] refill_g;
   logic [7:0]        blk_mask;
   logic              blk_start;
   logic [31:0]       granted_full;

   // request capture and limit register
   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         req_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_write_enable) begin
         limit_ff <= csr_write_data;
      end
   end

   // allocate decode: total size, class, page count
   assign total    = {1'b0, req_ff.request_size} + 25'(GRANULE_BYTES);
   assign page_sum = {1'b0, total} + 26'(PAGE_BYTES - 1);

   always_comb begin
      alloc_cls = CLS_W'(CLASS_COUNT - 1);
      for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
         if ({7'd0, total} <= (32'(GRANULE_BYTES) << i)) begin
            alloc_cls = CLS_W'(i);
         end
      end
   end

   // free decode: granule index and tag check
   assign free_g_full = 32'(req_ff.user_address[17:4]) - 32'd1;
   assign free_g      = free_g_full[GIDX_W-1:0];
   // pages not yet carved were never tagged
   assign tag_val  = ((free_g_full >> 8) >= 32'(nfp_ff)) ? 4'd0 : tag_rd_ff;
   assign free_cls = tag_val - 4'd1;

   // one head read port, class chosen by request kind
   assign head_idx = (req_ff.kind == KIND_FREE) ? free_cls[CLS_W-1:0] : alloc_cls;
   assign head_val = heads_ff[head_idx];
   assign head_m1  = head_val - LINK_W'(1);
   assign pop_g    = head_m1[GIDX_W-1:0];

   assign limit_eff = (32'(limit_ff) < REGION_PAGES) ? 32'(limit_ff) : REGION_PAGES;

   // refill walk over the 256 granules of the fresh page
   assign refill_g_full = (32'(nfp_ff) << 8) + 32'(fill_ff);
   assign refill_g      = refill_g_full[GIDX_W-1:0];
   assign blk_mask      = 8'((32'd1 << alloc_cls) - 32'd1);
   assign blk_start     = (fill_ff & blk_mask) == 8'd0;

   always_comb begin
      dp_status             = '0;
      dp_status.kind_free   = req_ff.kind == KIND_FREE;
      dp_status.zero_size   = req_ff.request_size == 24'd0;
      dp_status.oversize    = {7'd0, total} > 32'(LARGEST);
      dp_status.head_empty  = head_val == '0;
      dp_status.no_page     = 32'(nfp_ff) >= limit_eff;
      dp_status.addr_bad    = (req_ff.user_address[17:4] == 14'd0) ||
                              (req_ff.user_address[3:0] != 4'd0) ||
                              (free_g_full >= GRANULES);
      dp_status.tag_bad     = (tag_val == 4'd0) || (32'(tag_val) > CLASS_COUNT);
      dp_status.refill_last = fill_ff == 8'hFF;
   end

   // list heads and fresh page pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CLASS_COUNT; i++) begin
            heads_ff[i] <= '0;
         end
         nfp_ff <= '0;
      end else begin
         if (dp_cmd.refill_end) begin
            heads_ff[alloc_cls] <= prev_ff;
            nfp_ff              <= nfp_ff + PAGE_W'(1);
         end else if (dp_cmd.pop_commit) begin
            heads_ff[alloc_cls] <= link_rd_ff;
         end else if (dp_cmd.free_commit) begin
            heads_ff[head_idx] <= LINK_W'(free_g_full + 32'd1);
         end
      end
   end

   // refill walk counters
   always_ff @(posedge clock) begin
      if (dp_cmd.refill_start) begin
         fill_ff <= 8'd0;
         prev_ff <= '0;
      end else if (dp_cmd.refill_step) begin
         fill_ff <= fill_ff + 8'd1;
         if (blk_start) begin
            prev_ff <= LINK_W'(refill_g_full + 32'd1);
         end
      end
   end

   // link memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (dp_cmd.refill_step && blk_start) begin
         link_mem[refill_g] <= prev_ff;
      end else if (dp_cmd.free_commit) begin
         link_mem[free_g] <= head_val;
      end
      link_rd_ff <= link_mem[pop_g];
   end

   // tag memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (dp_cmd.refill_step) begin
         tag_mem[refill_g] <= 4'd0;
      end else if (dp_cmd.pop_commit) begin
         tag_mem[pop_g] <= 4'(alloc_cls) + 4'd1;
      end else if (dp_cmd.free_commit) begin
         tag_mem[free_g] <= 4'd0;
      end
      tag_rd_ff <= tag_mem[free_g];
   end

   // result assembly and output register
   assign granted_full = 32'(head_val) << 4;

   always_comb begin
      res_in        = '0;
      res_in.status = dp_cmd.result_status;
      unique case (dp_cmd.result_status)
         STATUS_ALLOCATED: begin
            res_in.granted_address = granted_full[17:0];
            res_in.size_class      = 4'(alloc_cls);
         end
         STATUS_OUT_OF_PAGES: begin
            res_in.size_class = 4'(alloc_cls);
         end
         STATUS_FREED: begin
            res_in.size_class = free_cls;
         end
         STATUS_LARGE: begin
            res_in.large_pages = page_sum[24:12];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load_result) begin
         res_ff <= res_in;
      end
      if (dp_cmd.deliver) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/size_class_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// size_class_free_list_allocator: segregated power-of-two block allocator
// Serves alloc and free requests over a region of 4096-byte pages with
// per-class LIFO free lists, carving fresh pages on demand.
//
//   channel   ports                                   direction
//   request   req_valid, req_stall, req_payload       in
//   result    rsp_valid, rsp_stall, rsp_payload       out
//   csr       csr_write_enable, csr_write_data        in
//
// A pop from a non-empty list or a free passes through the sequencer steps
// accept, decode, memory read-modify-write and deliver.
// An allocate that finds its list empty walks the 256 granules of a fresh
// page, one per cycle, then closes the walk and rereads the head.
// Reset empties all lists and rewinds the page pointer; it is synchronous.
// A stalled result holds in the output register.
// ----------------------------------------------------------------------------
module size_class_free_list_allocator #(
   parameter int unsigned REGION_PAGES = scfl_pkg::DEF_REGION_PAGES,
   parameter int unsigned CLASS_COUNT  = scfl_pkg::DEF_CLASS_COUNT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  scfl_pkg::req_payload_type  req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output scfl_pkg::rsp_payload_type  rsp_payload,
   input  logic                      csr_write_enable,
   input  logic [6:0]                csr_write_data
);
   import scfl_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // sequencer
   scfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // lists, memories, result
   scfl_datapath #(
      .REGION_PAGES (REGION_PAGES),
      .CLASS_COUNT  (CLASS_COUNT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status),
      .rsp_payload      (rsp_payload)
   );

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the size-class free-list allocator
// Drives alloc and free beats under random idling, predicts every result in a
// small scoreboard and checks each result beat field by field.
// ----------------------------------------------------------------------------
module tb_top;
   import scfl_pkg::*;

   localparam int unsigned NUM_GRANULES = DEF_REGION_PAGES * PAGE_GRANULES;
   localparam int unsigned MAX_CYCLES   = 1000000;
   localparam int unsigned HOLD_CYCLES  = 300;

   // Allocator predictor plus the queue of results still owed by the block
   class alloc_scoreboard;
      logic [14:0]     list_heads [DEF_CLASS_COUNT];
      logic [14:0]     next_links [NUM_GRANULES];
      logic [3:0]      class_tags [NUM_GRANULES];
      int unsigned     fresh_page;
      int unsigned     page_limit;
      rsp_payload_type owed_results[$];
      logic [17:0]     live_blocks[$];
      int unsigned     errors;

      function new();
         foreach (list_heads[i]) list_heads[i] = '0;
         foreach (next_links[i]) next_links[i] = '0;
         foreach (class_tags[i]) class_tags[i] = '0;
         fresh_page = 0;
         page_limit = LIMIT_RESET;
         errors     = 0;
      endfunction

      function void set_limit(logic [6:0] value);
         page_limit = value;
      endfunction

      function void push_free(int unsigned cls, int unsigned g);
         next_links[g]   = list_heads[cls];
         list_heads[cls] = 15'(g + 1);
      endfunction

      function rsp_payload_type predict_allocation(req_payload_type item);
         rsp_payload_type res;
         int unsigned     total, cls, g, lim, tag;
         res = '0;
         if (item.kind == KIND_ALLOC) begin
            total = item.request_size + GRANULE_BYTES;
            if (item.request_size == 0) begin
               res.status = STATUS_ZERO_SIZE;
            end else if (total > (GRANULE_BYTES << (DEF_CLASS_COUNT - 1))) begin
               res.status      = STATUS_LARGE;
               res.large_pages = 13'((total + PAGE_BYTES - 1) / PAGE_BYTES);
            end else begin
               cls = 0;
               while (cls + 1 < DEF_CLASS_COUNT && (GRANULE_BYTES << cls) < total) cls++;
               lim = (page_limit < DEF_REGION_PAGES) ? page_limit : DEF_REGION_PAGES;
               res.size_class = 4'(cls);
               if (list_heads[cls] == 0 && fresh_page >= lim) begin
                  res.status = STATUS_OUT_OF_PAGES;
               end else begin
                  // carve a fresh page, ascending, so the top block comes out first
                  if (list_heads[cls] == 0) begin
                     for (int unsigned i = 0; i < (PAGE_GRANULES >> cls); i++)
                        push_free(cls, fresh_page * PAGE_GRANULES + (i << cls));
                     fresh_page++;
                  end
                  g               = list_heads[cls] - 1;
                  list_heads[cls] = next_links[g];
                  class_tags[g]   = 4'(cls + 1);
                  res.status          = STATUS_ALLOCATED;
                  res.granted_address = 18'(g * GRANULE_BYTES + GRANULE_BYTES);
                  live_blocks.push_back(res.granted_address);
               end
            end
         end else begin
            res.status = STATUS_BAD_POINTER;
            if (item.user_address >= GRANULE_BYTES && item.user_address[3:0] == 0) begin
               g = (item.user_address - GRANULE_BYTES) / GRANULE_BYTES;
               if (g < NUM_GRANULES) begin
                  tag = class_tags[g];
                  if (tag != 0 && tag <= DEF_CLASS_COUNT) begin
                     class_tags[g] = '0;
                     push_free(tag - 1, g);
                     res.status     = STATUS_FREED;
                     res.size_class = 4'(tag - 1);
                     foreach (live_blocks[i])
                        if (live_blocks[i] == item.user_address) begin
                           live_blocks.delete(i);
                           break;
                        end
                  end
               end
            end
         end
         return res;
      endfunction

      function void note_request(req_payload_type item);
         owed_results.push_back(predict_allocation(item));
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (owed_results.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, got);
            errors++;
            return;
         end
         want = owed_results.pop_front();
         if (got.status !== want.status || got.granted_address !== want.granted_address ||
             got.size_class !== want.size_class || got.large_pages !== want.large_pages) begin
            $display("%0t: mismatch expected st=%0d addr=%h cls=%0d pages=%0d", $time,
                     want.status, want.granted_address, want.size_class, want.large_pages);
            $display("%0t:          actual   st=%0d addr=%h cls=%0d pages=%0d", $time,
                     got.status, got.granted_address, got.size_class, got.large_pages);
            errors++;
         end
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_write_enable = 1'b0;
   logic [6:0]      csr_write_data = '0;

   alloc_scoreboard book = new();
   int unsigned     send_idle_pct = 0;
   int unsigned     recv_idle_pct = 0;
   bit              hold_request = 0;
   int unsigned     hold_left = 0;
   int unsigned     cycle_count = 0;

   size_class_free_list_allocator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver: random stall, or a long hold-off when asked
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // result beat monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) book.check_result(rsp_payload);
   end

   // one request beat; starts and ends just after a rising edge
   task automatic send_request(input req_payload_type item);
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.note_request(item);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (book.owed_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(input logic [6:0] value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      book.set_limit(value);
   endtask

   function automatic req_payload_type make_alloc(input logic [23:0] size);
      req_payload_type item;
      item.kind         = KIND_ALLOC;
      item.request_size = size;
      item.user_address = 18'($urandom);
      return item;
   endfunction

   function automatic req_payload_type make_free(input logic [17:0] addr);
      req_payload_type item;
      item.kind         = KIND_FREE;
      item.request_size = 24'($urandom);
      item.user_address = addr;
      return item;
   endfunction

   // mostly sane alloc/free traffic with some raw noise
   function automatic req_payload_type random_request();
      req_payload_type item;
      int unsigned     pick, cls;
      pick = $urandom_range(99);
      if (pick >= 55 && pick < 85 && book.live_blocks.size() != 0) begin
         item = make_free(book.live_blocks[$urandom_range(book.live_blocks.size() - 1)]);
      end else if (pick < 85) begin
         cls  = ($urandom_range(99) < 80) ? $urandom_range(1, 4) : $urandom_range(5, 8);
         item = make_alloc(24'($urandom_range((8 << cls) - 15, (16 << cls) - 16)));
      end else begin
         item = req_payload_type'($urandom_range(1) ? {$urandom, $urandom} : '0);
         item.request_size = 24'($urandom);
         item.user_address = 18'($urandom);
         item.kind         = 1'($urandom);
      end
      return item;
   endfunction

   initial begin
      logic [17:0] addr;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_limit(7'd127);

      // directed: size extremes and bad pointers
      send_request(make_alloc(24'd0));
      send_request(make_alloc(24'hFFFFFF));
      send_request(make_alloc(24'd4081));
      send_request(make_alloc(24'd4080));
      send_request(make_alloc(24'd1));
      send_request(make_alloc(24'd16));
      send_request(make_free(18'd0));
      send_request(make_free(18'h3FFFF));
      send_request(make_free(18'h3FFF0));
      send_request(make_free(18'd16));
      send_request(make_free(18'd16));
      send_request(make_alloc(24'd100));
      addr = book.live_blocks[$];
      send_request(make_free(addr + 18'd16));
      send_request(make_free(addr));
      send_request(make_alloc(24'd4080));

      // no fresh page, and carved pages still usable after the limit drops
      write_limit(7'd0);
      send_request(make_alloc(24'd500));
      send_request(make_alloc(24'd10));
      send_request(make_alloc(24'd2000));

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 87 : 0;
         recv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 38 : 0;
         write_limit((phase == 0) ? 7'd64 : (phase == 1) ? 7'd12 : 7'd127);
         for (int n = 0; n < 265; n++) begin
            if (n == 130 && phase == 0) drain_results();
            if (n == 130 && phase == 2) hold_request = 1;
            send_request(random_request());
         end
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (book.errors == 0 && book.owed_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/scfl_pkg.sv
rtl/scfl_ctrl.sv
rtl/scfl_datapath.sv
rtl/size_class_free_list_allocator.sv
tb/sv/tb_top.sv
